[hdl/upa_pkg.sv]
package upa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;             // value width
  localparam int EW        = 31;             // error width
  localparam int QW        = W + FRAC_BITS;  // full quotient width of |a| / |b|
  localparam int PP_SPLIT  = 24;             // low slice width of the lane multiplier
  localparam int LANE_LAT  = EW + 4;         // depth of the side-band delay line across the error lanes

  localparam longint unsigned ONE_INT  = 64'd1 << FRAC_BITS;
  localparam longint unsigned TINY_INT = (ONE_INT + 64'd9999) / 64'd10000;

  localparam logic [W-1:0]  ONE_RAW  = W'(ONE_INT);
  localparam logic [EW-1:0] ONE_E    = EW'(ONE_INT);
  localparam logic [W-1:0]  TINY_RAW = W'(TINY_INT);

  localparam logic [W-1:0]  VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [W-1:0]  VAL_MIN  = 32'h8000_0000;
  localparam logic [EW-1:0] ERR_MAX  = 31'h7FFF_FFFF;
  localparam logic [W:0]    MAG_CAP  = 33'h1_0000_0000;
  localparam logic [W-1:0]  TERM_CAP = 32'h8000_0000;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_COMBINE,
    CMD_EQUAL,
    CMD_GREATER,
    CMD_LESS
  } cmd_t;

  // carried alongside the quotient divider
  typedef struct packed {
    cmd_t          cmd;
    logic [W-1:0]  a;
    logic [EW-1:0] ea;
    logic [W-1:0]  b;
    logic [EW-1:0] eb;
    logic          neg;
    logic          tiny_a;
    logic          tiny_b;
    logic          mb_zero;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [W:0]    r33;      // |a|*|b| >> FRAC_BITS, capped
  } dside_t;

  // carried alongside the error lanes
  typedef struct packed {
    cmd_t          cmd;
    logic [W-1:0]  a;
    logic [EW-1:0] ea;
    logic [W-1:0]  b;
    logic [EW-1:0] eb;
    logic          neg;
    logic          mb_zero;
    logic [W:0]    mag;      // product or quotient magnitude, capped
  } tside_t;

endpackage

[hdl/uncertainty_propagation_alu_core.sv]
// Values are signed Q16.16 (FRAC_BITS fraction bits); errors use the same scale.
// Throughput: one item per cycle; a stall on the result side freezes every stage.
// The depth comes from the restoring dividers, one quotient bit per stage:
// QW stages for |a|/|b| and 31 stages in each of the two error lanes.
// Reset clears the valid bits of all stages; the data registers are not reset.
module uncertainty_propagation_alu_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [2:0]                    cmd,
  input  logic signed [31:0]            a_value,
  input  logic [30:0]                   a_error,
  input  logic signed [31:0]            b_value,
  input  logic [30:0]                   b_error,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic signed [31:0]            r_value,
  output logic [30:0]                   r_error,
  output logic                          truth,
  output logic                          fault
);

  localparam int W  = upa_pkg::W;
  localparam int EW = upa_pkg::EW;
  localparam int QW = upa_pkg::QW;
  localparam int F  = upa_pkg::FRAC_BITS;
  localparam int L  = upa_pkg::LANE_LAT;

  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // input stage
  logic                v1;
  upa_pkg::cmd_t       c1;
  logic [W-1:0]        a1, b1;
  logic [EW-1:0]       ea1, eb1;
  logic [W-1:0]        ma1, mb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= upa_pkg::cmd_t'(cmd);
      a1  <= a_value;
      ea1 <= a_error;
      b1  <= b_value;
      eb1 <= b_error;
    end
  end

  assign ma1 = a1[W-1] ? (~a1 + 32'd1) : a1;
  assign mb1 = b1[W-1] ? (~b1 + 32'd1) : b1;

  // quotient divider chain, index 0 loaded from the input stage
  logic                 dv [0:QW];
  upa_pkg::dside_t      ds [0:QW];
  logic [W-1:0]         dr [0:QW];
  logic [QW-1:0]        nq [0:QW];
  logic [2*W-1:0]       p0;
  logic [W:0]           r33_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].cmd     <= c1;
      ds[0].a       <= a1;
      ds[0].ea      <= ea1;
      ds[0].b       <= b1;
      ds[0].eb      <= eb1;
      ds[0].neg     <= a1[W-1] ^ b1[W-1];
      ds[0].tiny_a  <= ma1 < upa_pkg::TINY_RAW;
      ds[0].tiny_b  <= mb1 < upa_pkg::TINY_RAW;
      ds[0].mb_zero <= mb1 == '0;
      ds[0].ma      <= ma1;
      ds[0].mb      <= mb1;
      ds[0].r33     <= '0;
      dr[0]         <= '0;
      nq[0]         <= {ma1, {F{1'b0}}};
      p0            <= {{W{1'b0}}, ma1} * {{W{1'b0}}, mb1};
    end
  end

  assign r33_0 = (|p0[2*W-1:W+F]) ? upa_pkg::MAG_CAP : {1'b0, p0[W+F-1:F]};

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [W:0]      t;
    logic [W:0]      diff;
    logic            ge;
    upa_pkg::dside_t snx;

    assign t    = {dr[k], nq[k][QW-1]};
    assign diff = t - {1'b0, ds[k].mb};
    assign ge   = t >= {1'b0, ds[k].mb};

    always_comb begin
      snx = ds[k];
      if (k == 0) begin
        snx.r33 = r33_0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1] <= ge ? diff[W-1:0] : t[W-1:0];
        nq[k+1] <= {nq[k][QW-2:0], ge};
        ds[k+1] <= snx;
      end
    end
  end

  // operand selection for the error lanes
  upa_pkg::dside_t s_q;
  logic [QW-1:0]   q;
  logic [W:0]      qmag;
  logic            is_mul;
  logic [QW-1:0]   xa, xb;
  logic [EW-1:0]   ya, yb;
  logic [W-1:0]    da, db;
  logic [W-1:0]    ta, tb;

  logic            tv [0:L];
  upa_pkg::tside_t ts [0:L];

  assign s_q    = ds[QW];
  assign q      = nq[QW];
  assign qmag   = (|q[QW-1:W]) ? upa_pkg::MAG_CAP : {1'b0, q[W-1:0]};
  assign is_mul = s_q.cmd == upa_pkg::CMD_MUL;

  // r is small whenever a tiny operand selects it, so the widening is exact
  always_ff @(posedge clk) begin
    if (en) begin
      if (is_mul) begin
        xa <= s_q.tiny_a ? QW'(s_q.r33) : QW'(s_q.mb);
        ya <= s_q.ea;
        da <= upa_pkg::ONE_RAW;
        xb <= s_q.tiny_b ? QW'(s_q.r33) : QW'(s_q.ma);
        db <= upa_pkg::ONE_RAW;
      end else begin
        xa <= s_q.tiny_a ? q : QW'(s_q.ea);
        ya <= s_q.tiny_a ? s_q.ea : upa_pkg::ONE_E;
        da <= s_q.tiny_a ? upa_pkg::ONE_RAW : s_q.mb;
        xb <= q;
        db <= s_q.mb;
      end
      yb            <= s_q.eb;
      ts[0].cmd     <= s_q.cmd;
      ts[0].a       <= s_q.a;
      ts[0].ea      <= s_q.ea;
      ts[0].b       <= s_q.b;
      ts[0].eb      <= s_q.eb;
      ts[0].neg     <= s_q.neg;
      ts[0].mb_zero <= s_q.mb_zero;
      ts[0].mag     <= is_mul ? s_q.r33 : qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (en) begin
      tv[0] <= dv[QW];
    end
  end

  upa_err_lane u_lane_a (
    .clk  (clk),
    .en   (en),
    .x    (xa),
    .y    (ya),
    .d    (da),
    .term (ta)
  );

  upa_err_lane u_lane_b (
    .clk  (clk),
    .en   (en),
    .x    (xb),
    .y    (yb),
    .d    (db),
    .term (tb)
  );

  for (genvar k = 0; k < L; k++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[k+1] <= 1'b0;
      end else if (en) begin
        tv[k+1] <= tv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ts[k+1] <= ts[k];
      end
    end
  end

  // E1: sums
  upa_pkg::tside_t s1;
  logic            e1v;
  upa_pkg::tside_t e1s;
  logic [W:0]      sadd, ssub, sba, ahi, alo, bhi, blo, esum;
  logic [W-1:0]    eab;
  logic [W:0]      a33, b33, ea33, eb33;

  assign s1   = ts[L];
  assign a33  = {s1.a[W-1], s1.a};
  assign b33  = {s1.b[W-1], s1.b};
  assign ea33 = {2'b00, s1.ea};
  assign eb33 = {2'b00, s1.eb};

  always_ff @(posedge clk) begin
    if (en) begin
      e1s  <= s1;
      sadd <= a33 + b33;
      ssub <= a33 - b33;
      sba  <= b33 - a33;
      ahi  <= a33 + ea33;
      alo  <= a33 - ea33;
      bhi  <= b33 + eb33;
      blo  <= b33 - eb33;
      eab  <= {1'b0, s1.ea} + {1'b0, s1.eb};
      esum <= {1'b0, ta} + {1'b0, tb};
    end
  end

  // E2: clamps, compares, interval ends
  logic            e2v;
  upa_pkg::cmd_t   e2c;
  logic [W-1:0]    pv;
  logic [EW-1:0]   pe;
  logic            pt, pf;
  logic [W:0]      hi, lo;
  logic [W-1:0]    pv_n;
  logic [EW-1:0]   pe_n;
  logic            pt_n, pf_n;
  logic [W:0]      dabs;

  assign dabs = ssub[W] ? sba : ssub;

  always_comb begin
    pv_n = '0;
    pe_n = '0;
    pt_n = 1'b0;
    pf_n = 1'b0;
    case (e1s.cmd)
      upa_pkg::CMD_ADD, upa_pkg::CMD_SUB: begin
        if (e1s.cmd == upa_pkg::CMD_ADD) begin
          pv_n = sadd[W-1:0];
          if (sadd[W] != sadd[W-1]) begin
            pv_n = sadd[W] ? upa_pkg::VAL_MIN : upa_pkg::VAL_MAX;
            pf_n = 1'b1;
          end
        end else begin
          pv_n = ssub[W-1:0];
          if (ssub[W] != ssub[W-1]) begin
            pv_n = ssub[W] ? upa_pkg::VAL_MIN : upa_pkg::VAL_MAX;
            pf_n = 1'b1;
          end
        end
        pe_n = eab[EW-1:0];
        if (eab[W-1]) begin
          pe_n = upa_pkg::ERR_MAX;
          pf_n = 1'b1;
        end
      end
      upa_pkg::CMD_MUL, upa_pkg::CMD_DIV: begin
        if (e1s.neg) begin
          pv_n = ~e1s.mag[W-1:0] + 32'd1;
          if (e1s.mag > {1'b0, upa_pkg::VAL_MIN}) begin
            pv_n = upa_pkg::VAL_MIN;
            pf_n = 1'b1;
          end
        end else begin
          pv_n = e1s.mag[W-1:0];
          if (e1s.mag[W] || e1s.mag[W-1]) begin
            pv_n = upa_pkg::VAL_MAX;
            pf_n = 1'b1;
          end
        end
        pe_n = esum[EW-1:0];
        if (esum[W] || esum[W-1]) begin
          pe_n = upa_pkg::ERR_MAX;
          pf_n = 1'b1;
        end
        // zero divisor
        if (e1s.cmd == upa_pkg::CMD_DIV && e1s.mb_zero) begin
          pv_n = e1s.a[W-1] ? upa_pkg::VAL_MIN : upa_pkg::VAL_MAX;
          pe_n = upa_pkg::ERR_MAX;
          pf_n = 1'b1;
        end
      end
      upa_pkg::CMD_EQUAL: begin
        pt_n = (dabs <= {2'b00, e1s.ea}) || (dabs <= {2'b00, e1s.eb});
      end
      upa_pkg::CMD_GREATER: begin
        pt_n = $signed(ahi) > $signed(blo);
      end
      upa_pkg::CMD_LESS: begin
        pt_n = $signed(alo) < $signed(bhi);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2c <= e1s.cmd;
      pv  <= pv_n;
      pe  <= pe_n;
      pt  <= pt_n;
      pf  <= pf_n;
      hi  <= ($signed(bhi) < $signed(ahi)) ? bhi : ahi;
      lo  <= ($signed(blo) > $signed(alo)) ? blo : alo;
    end
  end

  // E3: midpoint and width of the intersection
  logic            e3v;
  upa_pkg::cmd_t   e3c;
  logic [W-1:0]    qv;
  logic [EW-1:0]   qe;
  logic            qt, qf;
  logic [W+1:0]    csum, cdif;

  always_ff @(posedge clk) begin
    if (en) begin
      e3c  <= e2c;
      qv   <= pv;
      qe   <= pe;
      qt   <= pt;
      qf   <= pf;
      csum <= {hi[W], hi} + {lo[W], lo};
      cdif <= {hi[W], hi} - {lo[W], lo};
    end
  end

  // E4: output register
  logic [W:0]   half;
  logic [W+1:0] dmag;
  logic [W:0]   eh;
  logic         hovf, eovf;

  assign half = csum[W+1:1];
  assign hovf = half[W] != half[W-1];
  assign dmag = cdif[W+1] ? (~cdif + 34'd1) : cdif;
  assign eh   = dmag[W+1:1];
  assign eovf = eh[W] || eh[W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (e3c == upa_pkg::CMD_COMBINE) begin
        r_value <= hovf ? (half[W] ? upa_pkg::VAL_MIN : upa_pkg::VAL_MAX) : half[W-1:0];
        r_error <= eovf ? upa_pkg::ERR_MAX : eh[EW-1:0];
        truth   <= 1'b0;
        fault   <= hovf || eovf;
      end else begin
        r_value <= qv;
        r_error <= qe;
        truth   <= qt;
        fault   <= qf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1v       <= 1'b0;
      e2v       <= 1'b0;
      e3v       <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      e1v       <= tv[L];
      e2v       <= e1v;
      e3v       <= e2v;
      rsp_valid <= e3v;
    end
  end

endmodule

[hdl/upa_err_lane.sv]
// floor(x*y/d), saturated to TERM_CAP; one quotient bit per stage
module upa_err_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [upa_pkg::QW-1:0]   x,
  input  logic [upa_pkg::EW-1:0]   y,
  input  logic [upa_pkg::W-1:0]    d,
  output logic [upa_pkg::W-1:0]    term
);

  localparam int NW = upa_pkg::QW + upa_pkg::EW;
  localparam int LW = upa_pkg::PP_SPLIT + upa_pkg::EW;
  localparam int HW = upa_pkg::QW - upa_pkg::PP_SPLIT + upa_pkg::EW;

  logic [LW-1:0]          ppl;
  logic [HW-1:0]          pph;
  logic [upa_pkg::W-1:0]  d_a;
  logic [NW-1:0]          n;
  logic [upa_pkg::W-1:0]  d_b;
  logic [upa_pkg::QW-1:0] n_hi;

  logic [upa_pkg::W-1:0]  rem [0:upa_pkg::EW];
  logic [upa_pkg::EW-1:0] nq  [0:upa_pkg::EW];
  logic [upa_pkg::W-1:0]  dd  [0:upa_pkg::EW];
  logic                   ov  [0:upa_pkg::EW];

  always_ff @(posedge clk) begin
    if (en) begin
      ppl <= {{upa_pkg::EW{1'b0}}, x[upa_pkg::PP_SPLIT-1:0]}
           * {{upa_pkg::PP_SPLIT{1'b0}}, y};
      pph <= {{upa_pkg::EW{1'b0}}, x[upa_pkg::QW-1:upa_pkg::PP_SPLIT]}
           * {{(upa_pkg::QW-upa_pkg::PP_SPLIT){1'b0}}, y};
      d_a <= d;
      n   <= {pph, {upa_pkg::PP_SPLIT{1'b0}}} + {{(NW-LW){1'b0}}, ppl};
      d_b <= d_a;
    end
  end

  assign n_hi = n[NW-1:upa_pkg::EW];

  // quotient fits the field only if the top part stays below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= n_hi >= {{(upa_pkg::QW-upa_pkg::W){1'b0}}, d_b};
      rem[0] <= n_hi[upa_pkg::W-1:0];
      nq[0]  <= n[upa_pkg::EW-1:0];
      dd[0]  <= d_b;
    end
  end

  for (genvar k = 0; k < upa_pkg::EW; k++) begin : g_step
    logic [upa_pkg::W:0] t;
    logic [upa_pkg::W:0] diff;
    logic                ge;

    assign t    = {rem[k], nq[k][upa_pkg::EW-1]};
    assign diff = t - {1'b0, dd[k]};
    assign ge   = t >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[upa_pkg::W-1:0] : t[upa_pkg::W-1:0];
        nq[k+1]  <= {nq[k][upa_pkg::EW-2:0], ge};
        dd[k+1]  <= dd[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term <= ov[upa_pkg::EW] ? upa_pkg::TERM_CAP : {1'b0, nq[upa_pkg::EW]};
    end
  end

endmodule
